/* design/gbb_pkg.sv */
// gbb_pkg: shared types and constants of the glyph bitmap blitter
// holds the request codes, the queued item layout and status structs
// depends on nothing
package gbb_pkg;

   // request codes as they arrive on req_type
   localparam logic [1:0] REQ_BLIT  = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // configuration register indexes
   localparam logic CSR_SCALE  = 1'b0;
   localparam logic CSR_ROTATE = 1'b1;

   // scale codes that draw something
   localparam logic [1:0] SCALE_SINGLE = 2'd1;
   localparam logic [1:0] SCALE_DOUBLE = 2'd2;

   // byte constants
   localparam logic [7:0] BIT_MSB    = 8'h80;
   localparam logic [7:0] BYTE_WHITE = 8'hff;

   // signed pixel coordinate width, wide enough for origin, offset and rotation
   localparam int COORD_W = 14;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // what the back end has to do with an item
   typedef enum logic [1:0] {
      K_BLIT,
      K_CLEAR,
      K_READ,
      K_NOP
   } kind_type;

   // one classified item as it waits in the queue
   typedef struct packed {
      kind_type           kind;
      logic signed [10:0] origin_x;
      logic signed [10:0] origin_y;
      logic [6:0]         column;
      logic [3:0]         row_byte;
      logic [7:0]         active;      // bit b set: glyph row row_byte*8+b is drawn
      logic               double_px;   // 2x2 blocks
      logic               cursor_set;  // cursor takes column at the end
      logic               read_ok;     // read address inside the store
      logic [13:0]        read_addr;
   } item_type;

   // queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // back end status
   typedef struct packed {
      logic busy;
      logic rsp_is_read;
   } back_stat_type;

endpackage

/* design/glyph_bitmap_blitter_unit.sv */
// glyph_bitmap_blitter_unit: top level of the one-bit frame buffer glyph blitter
// holds the configuration registers and joins front, queue and back
// depends on gbb_pkg, gbb_front, gbb_queue, gbb_back
//
// A one-bit-per-pixel frame buffer (cleared bit = black) of FRAME_WIDTH by FRAME_HEIGHT
// pixels, ((FRAME_WIDTH+7)/8)*FRAME_HEIGHT bytes in one single-port-style memory. Every
// item gives exactly one result: read_data is the addressed byte for a read and zero
// otherwise, last_column is the cursor after the item. The front end classifies items and
// queues up to four, so items keep being taken while the back end is busy or a result
// waits. Back end time per item is set by the one store read and one store write per
// pixel written: a blit picks up the item, passes over each glyph row that is skipped
// (bit clear, at or beyond the glyph height, or an unused scale), reads and writes each
// pixel kept and drops each pixel clipped (one pixel per set row at scale 1, four at
// scale 2), then gives the result; a clear is a sweep of one byte a cycle over the whole
// store; a read fetches the addressed byte (zero outside the store). The store holds
// garbage after reset until the first clear. The user ensures that scale (register 0) and
// rotate (register 1) are written only while no item is in flight; it is not enforced.
module glyph_bitmap_blitter_unit #(
   parameter int FRAME_WIDTH  = 400,
   parameter int FRAME_HEIGHT = 300
) (
   input  logic               clock,
   input  logic               reset,
   // item channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic signed [10:0] req_origin_x,
   input  logic signed [10:0] req_origin_y,
   input  logic [6:0]         req_column,
   input  logic [3:0]         req_row_byte,
   input  logic [7:0]         req_glyph_height,
   input  logic [7:0]         req_bits,
   input  logic [13:0]        req_read_addr,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data,
   output logic [6:0]         rsp_last_column,
   // configuration channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [1:0]         csr_data
);

   logic [1:0]             scale_ff;
   logic                   rotate_ff;
   logic                   push, pop;
   gbb_pkg::item_type      push_item, pop_item;
   gbb_pkg::q_stat_type    q_stat;
   gbb_pkg::back_stat_type back_stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= gbb_pkg::SCALE_SINGLE;
         rotate_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gbb_pkg::CSR_SCALE: begin
               scale_ff <= csr_data;
            end
            gbb_pkg::CSR_ROTATE: begin
               rotate_ff <= csr_data[0];
            end
            default: begin
               scale_ff <= scale_ff;
            end
         endcase
      end
   end

   // front end
   gbb_front #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_column       (req_column),
      .req_row_byte     (req_row_byte),
      .req_glyph_height (req_glyph_height),
      .req_bits         (req_bits),
      .req_read_addr    (req_read_addr),
      .scale            (scale_ff),
      .q_stat           (q_stat),
      .push             (push),
      .push_item        (push_item)
   );

   // item queue
   gbb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_stat    (q_stat)
   );

   // back end
   gbb_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .rotate          (rotate_ff),
      .q_stat          (q_stat),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_data   (rsp_read_data),
      .rsp_last_column (rsp_last_column),
      .back_stat       (back_stat)
   );

   // a waiting item is always picked up by an idle back end
   a_pickup: assert property (@(posedge clock) disable iff (reset)
      (!q_stat.empty && !back_stat.busy) |=> back_stat.busy)
      else $error("queued item not taken by idle back end");

   // only reads return data
   a_read_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !back_stat.rsp_is_read) |-> (rsp_read_data == 8'h00))
      else $error("non-read result carries data");

   // the cursor moves only together with a new result
   a_cursor: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$rose(rsp_valid)) |-> $stable(rsp_last_column))
      else $error("cursor changed without a result");

endmodule

/* design/gbb_front.sv */
// gbb_front: request handshake and classification of items
// works out which glyph rows draw and whether the cursor moves
// depends on gbb_pkg
module gbb_front #(
   parameter int FRAME_WIDTH  = 400,
   parameter int FRAME_HEIGHT = 300
) (
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic signed [10:0]  req_origin_x,
   input  logic signed [10:0]  req_origin_y,
   input  logic [6:0]          req_column,
   input  logic [3:0]          req_row_byte,
   input  logic [7:0]          req_glyph_height,
   input  logic [7:0]          req_bits,
   input  logic [13:0]         req_read_addr,
   input  logic [1:0]          scale,
   input  gbb_pkg::q_stat_type q_stat,
   output logic                push,
   output gbb_pkg::item_type   push_item
);

   localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;

   logic       scale_ok;
   logic [7:0] active;

   // take an item whenever the queue has room
   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   assign scale_ok = (scale == gbb_pkg::SCALE_SINGLE) || (scale == gbb_pkg::SCALE_DOUBLE);

   // rows with a set bit and below the glyph height, at a drawing scale, msb first
   always_comb begin
      for (int b = 0; b < 8; b++) begin
         active[b] = req_bits[7 - b] && scale_ok &&
                     ({1'b0, req_row_byte, 3'(b)} < req_glyph_height);
      end
   end

   // classify the item
   always_comb begin
      push_item            = '0;
      push_item.origin_x   = req_origin_x;
      push_item.origin_y   = req_origin_y;
      push_item.column     = req_column;
      push_item.row_byte   = req_row_byte;
      push_item.read_addr  = req_read_addr;
      push_item.read_ok    = (32'(req_read_addr) < 32'(STORE_BYTES));
      push_item.double_px  = (scale == gbb_pkg::SCALE_DOUBLE);
      case (req_type)
         gbb_pkg::REQ_BLIT: begin
            push_item.kind       = gbb_pkg::K_BLIT;
            push_item.active     = active;
            push_item.cursor_set = (scale == gbb_pkg::SCALE_SINGLE) && (|active);
         end
         gbb_pkg::REQ_CLEAR: begin
            push_item.kind = gbb_pkg::K_CLEAR;
         end
         gbb_pkg::REQ_READ: begin
            push_item.kind = gbb_pkg::K_READ;
         end
         default: begin
            push_item.kind = gbb_pkg::K_NOP;
         end
      endcase
   end

endmodule

/* design/gbb_queue.sv */
// gbb_queue: short fifo of classified items between front and back
// depends on gbb_pkg
module gbb_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gbb_pkg::item_type   push_item,
   input  logic                pop,
   output gbb_pkg::item_type   pop_item,
   output gbb_pkg::q_stat_type q_stat
);

   gbb_pkg::item_type                 slots_ff [gbb_pkg::QUEUE_DEPTH];
   logic [gbb_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [gbb_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [gbb_pkg::QPTR_W:0]          count_ff, count_in;

   assign q_stat.full  = (count_ff == (gbb_pkg::QPTR_W + 1)'(gbb_pkg::QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign pop_item     = slots_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/gbb_back.sv */
// gbb_back: carries out items against the frame store
// pixel read-modify-write sequencer, clear sweep, byte read and result register
// depends on gbb_pkg
module gbb_back #(
   parameter int FRAME_WIDTH  = 400,
   parameter int FRAME_HEIGHT = 300
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rotate,
   input  gbb_pkg::q_stat_type   q_stat,
   input  gbb_pkg::item_type     pop_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_read_data,
   output logic [6:0]            rsp_last_column,
   output gbb_pkg::back_stat_type back_stat
);

   localparam int ROW_BYTES   = (FRAME_WIDTH + 7) / 8;
   localparam int STORE_BYTES = ROW_BYTES * FRAME_HEIGHT;
   localparam int ADDR_W      = $clog2(STORE_BYTES);
   localparam int CW          = gbb_pkg::COORD_W;

   localparam logic signed [CW-1:0] FW_S  = CW'(FRAME_WIDTH);
   localparam logic signed [CW-1:0] FH_S  = CW'(FRAME_HEIGHT);
   localparam logic signed [CW-1:0] FH_M1 = CW'(FRAME_HEIGHT - 1);
   localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_CLEAR,
      S_PIX,
      S_ADDR,
      S_RD,
      S_WR,
      S_NEXT,
      S_RDREQ,
      S_RDDAT,
      S_RSP
   } state_type;

   state_type          state_ff;
   gbb_pkg::item_type  cur_ff;
   logic [2:0]         bit_ff;
   logic [1:0]         sub_ff;
   logic [CW-2:0]      rx_ff, ry_ff;
   logic               keep_ff;
   logic [ADDR_W-1:0]  pix_addr_ff;
   logic [7:0]         mask_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [6:0]         cursor_ff;
   logic               rsp_valid_ff;
   logic [7:0]         rsp_data_ff;
   logic               rsp_read_ff;

   // frame store and its registered read port
   logic [7:0]         mem [STORE_BYTES];
   logic [7:0]         rd_q_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [7:0]         mem_wdata;

   // pixel coordinates of the current bit and sub-pixel
   logic [6:0]           row7;
   logic signed [CW-1:0] ox_ext, oy_ext, px, py, rx, ry;
   logic                 keep;
   logic [ADDR_W-1:0]    pix_addr_in;
   logic [7:0]           mask_in;

   assign pop = (state_ff == S_IDLE) && !q_stat.empty;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_last_column = cursor_ff;

   assign back_stat.busy        = (state_ff != S_IDLE);
   assign back_stat.rsp_is_read = rsp_read_ff;

   // glyph position to frame position, with rotation and clipping
   always_comb begin
      row7   = {cur_ff.row_byte, bit_ff};
      ox_ext = CW'(cur_ff.origin_x);
      oy_ext = CW'(cur_ff.origin_y);
      if (cur_ff.double_px) begin
         px = ox_ext + $signed(CW'({row7, sub_ff[0]}));
         py = oy_ext + $signed(CW'({cur_ff.column, sub_ff[1]}));
      end else begin
         px = ox_ext + $signed(CW'(row7));
         py = oy_ext + $signed(CW'(cur_ff.column));
      end
      if (rotate) begin
         rx = py;
         ry = FH_M1 - px;
      end else begin
         rx = px;
         ry = py;
      end
      keep = !rx[CW-1] && !ry[CW-1] && (rx < FW_S) && (ry < FH_S);
   end

   // byte address and bit mask of the kept pixel
   assign pix_addr_in = ADDR_W'(ry_ff) * ADDR_W'(ROW_BYTES) + ADDR_W'(rx_ff >> 3);
   assign mask_in     = gbb_pkg::BIT_MSB >> rx_ff[2:0];

   // store port selection
   always_comb begin
      mem_we    = (state_ff == S_CLEAR) || (state_ff == S_WR);
      mem_waddr = (state_ff == S_CLEAR) ? clr_ff : pix_addr_ff;
      mem_wdata = (state_ff == S_CLEAR) ? gbb_pkg::BYTE_WHITE : (rd_q_ff & ~mask_ff);
      mem_raddr = (state_ff == S_RDREQ) ? ADDR_W'(cur_ff.read_addr) : pix_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_q_ff <= mem[mem_raddr];
   end

   // sequencer with the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_read_ff  <= 1'b0;
         cursor_ff    <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (!q_stat.empty) begin
                  cur_ff      <= pop_item;
                  bit_ff      <= '0;
                  sub_ff      <= '0;
                  clr_ff      <= '0;
                  rsp_data_ff <= '0;
                  rsp_read_ff <= (pop_item.kind == gbb_pkg::K_READ);
                  case (pop_item.kind)
                     gbb_pkg::K_BLIT: begin
                        state_ff <= S_PIX;
                     end
                     gbb_pkg::K_CLEAR: begin
                        state_ff <= S_CLEAR;
                     end
                     gbb_pkg::K_READ: begin
                        state_ff <= S_RDREQ;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= S_RSP;
                     end
                  endcase
               end
            end
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == LAST_ADDR) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_RSP;
               end
            end
            S_PIX: begin
               if (cur_ff.active[bit_ff]) begin
                  rx_ff    <= rx[CW-2:0];
                  ry_ff    <= ry[CW-2:0];
                  keep_ff  <= keep;
                  state_ff <= S_ADDR;
               end else begin
                  // nothing drawn for this row: move straight to the next one
                  sub_ff   <= 2'd3;
                  state_ff <= S_NEXT;
               end
            end
            S_ADDR: begin
               pix_addr_ff <= pix_addr_in;
               mask_ff     <= mask_in;
               state_ff    <= keep_ff ? S_RD : S_NEXT;
            end
            S_RD: begin
               state_ff <= S_WR;
            end
            S_WR: begin
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (cur_ff.double_px && (sub_ff != 2'd3)) begin
                  sub_ff   <= sub_ff + 1'b1;
                  state_ff <= S_PIX;
               end else begin
                  sub_ff <= '0;
                  if (bit_ff == 3'd7) begin
                     if (cur_ff.cursor_set) begin
                        cursor_ff <= cur_ff.column;
                     end
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_RSP;
                  end else begin
                     bit_ff   <= bit_ff + 1'b1;
                     state_ff <= S_PIX;
                  end
               end
            end
            S_RDREQ: begin
               state_ff <= S_RDDAT;
            end
            S_RDDAT: begin
               rsp_data_ff  <= cur_ff.read_ok ? rd_q_ff : 8'h00;
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RSP;
            end
            S_RSP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
